// ----- design/obb_pkg.sv -----
// Shared constants, command/status types and operation codes for the
// oriented-box overlap unit. No dependencies; imported by every module.
`timescale 1ns / 1ps
`default_nettype none

package obb_pkg;

  // Fixed-point format of the stored vectors.
  localparam int COORD_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;

  localparam int CW        = COORD_WIDTH;
  localparam int IN_W      = 32;
  localparam int SLOT_W    = 4;
  localparam int NUM_SLOTS = 10;

  // Widths of the working registers.
  localparam int DW         = CW + 1;       // centre difference
  localparam int NW         = 2 * CW + 2;   // test axis (cross products)
  localparam int YW         = CW + 1;       // narrow multiplier operand
  localparam int MUL_CHUNKS = 4;            // CW-bit slices of the wide operand
  localparam int MX_W       = MUL_CHUNKS * CW;
  localparam int MCNT_W     = $clog2(MUL_CHUNKS);
  localparam int ACC_W      = 4 * CW + 12;

  // Slot map of the vector store.
  localparam logic [SLOT_W-1:0] SLOT_CA  = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_AXA = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_HA  = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_CB  = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_AXB = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_HB  = 4'd9;

  // Datapath operations.
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_WRITE    = 4'd1;
  localparam logic [3:0] OP_ACC_CLR  = 4'd2;
  localparam logic [3:0] OP_ACC_LD   = 4'd3;
  localparam logic [3:0] OP_ACC_SUB  = 4'd4;
  localparam logic [3:0] OP_D_SET    = 4'd5;
  localparam logic [3:0] OP_T_LD     = 4'd6;
  localparam logic [3:0] OP_N_LD_ST  = 4'd7;
  localparam logic [3:0] OP_N_LD_ACC = 4'd8;
  localparam logic [3:0] OP_MUL      = 4'd9;
  localparam logic [3:0] OP_LHS_SET  = 4'd10;
  localparam logic [3:0] OP_RHS_CLR  = 4'd11;
  localparam logic [3:0] OP_RHS_OWN  = 4'd12;
  localparam logic [3:0] OP_CMP      = 4'd13;

  // Wide multiplier operand sources.
  localparam logic [1:0] X_T   = 2'd0;
  localparam logic [1:0] X_N   = 2'd1;
  localparam logic [1:0] X_ACC = 2'd2;
  localparam logic       Y_ST  = 1'b0;
  localparam logic       Y_D   = 1'b1;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        xsel;
    logic              ysel;
    logic              neg;
    logic              mag;
    logic              to_rhs;
    logic [1:0]        idx;
    logic [SLOT_W-1:0] rd_slot;
    logic [1:0]        rd_comp;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic sep;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- design/obb_dpath.sv -----
// Datapath of the overlap unit: vector store, working registers and a shared
// sequential multiply-accumulate unit. Depends on obb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obb_dpath import obb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [SLOT_W-1:0] slot,
  input  logic [IN_W-1:0]   comp_x,
  input  logic [IN_W-1:0]   comp_y,
  input  logic [IN_W-1:0]   comp_z
);

  logic [CW-1:0]            vs [NUM_SLOTS][3];
  logic [NUM_SLOTS-1:0]     vld;
  logic signed [CW-1:0]     rd;
  logic signed [CW:0]       rdx;
  logic [CW:0]              rmag;
  logic signed [DW-1:0]     d [3];
  logic signed [CW-1:0]     t [3];
  logic signed [NW-1:0]     n [3];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rhs;
  logic [ACC_W-1:0]         lhs;
  logic [ACC_W-1:0]         amag;
  logic                     sep;

  logic                     mbusy;
  logic [MCNT_W-1:0]        mcnt;
  logic [MX_W-1:0]          mx;
  logic [YW-1:0]            my;
  logic                     msign;
  logic                     mrhs;
  logic signed [MX_W-1:0]   xv;
  logic signed [YW-1:0]     yv;
  logic [MX_W-1:0]          xmag;
  logic [YW-1:0]            ymag;
  logic [CW+YW-1:0]         part;
  logic [ACC_W-1:0]         pshift;
  logic [ACC_W-1:0]         pterm;
  logic                     mlast;

  // Entries never written since reset read as zero.
  always_comb begin
    rd   = vld[cmd.rd_slot] ? vs[cmd.rd_slot][cmd.rd_comp] : '0;
    rdx  = (CW+1)'(rd);
    rmag = rdx[CW] ? (CW+1)'(-rdx) : (CW+1)'(rdx);
    amag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.op == OP_WRITE) begin
      vld[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE) begin
      vs[slot][0] <= comp_x[CW-1:0];
      vs[slot][1] <= comp_y[CW-1:0];
      vs[slot][2] <= comp_z[CW-1:0];
    end
  end

  // Operand selection for the multiplier; magnitudes are multiplied and the
  // sign is applied when each partial product is accumulated.
  always_comb begin
    case (cmd.xsel)
      X_T:     xv = MX_W'(t[cmd.idx]);
      X_N:     xv = MX_W'(n[cmd.idx]);
      X_ACC:   xv = acc[MX_W-1:0];
      default: xv = '0;
    endcase
    yv   = (cmd.ysel == Y_D) ? d[cmd.idx] : YW'(rd);
    xmag = xv[MX_W-1] ? MX_W'(-xv) : MX_W'(xv);
    ymag = yv[YW-1] ? YW'(-yv) : YW'(yv);
  end

  always_comb begin
    part   = mx[CW*mcnt +: CW] * my;
    pshift = ACC_W'(part) << (CW * mcnt);
    pterm  = msign ? (~pshift + ACC_W'(1)) : pshift;
    mlast  = (mcnt == MCNT_W'(MUL_CHUNKS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mcnt  <= '0;
    end else if (cmd.op == OP_MUL) begin
      mbusy <= 1'b1;
      mcnt  <= '0;
    end else if (mbusy) begin
      mcnt <= mcnt + MCNT_W'(1);
      if (mlast) begin
        mbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL) begin
      mx    <= xmag;
      my    <= ymag;
      msign <= cmd.mag ? 1'b0 : (xv[MX_W-1] ^ yv[YW-1] ^ cmd.neg);
      mrhs  <= cmd.to_rhs;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACC_CLR:  acc <= '0;
      OP_ACC_LD:   acc <= ACC_W'(rd);
      OP_ACC_SUB:  acc <= acc - ACC_W'(rd);
      default: begin
      end
    endcase
    if (mbusy && !mrhs) begin
      acc <= acc + pterm;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RHS_CLR: rhs <= '0;
      OP_RHS_OWN: rhs <= ACC_W'(rmag) << (2 * FRACTION_BITS);
      default: begin
      end
    endcase
    if (mbusy && mrhs) begin
      rhs <= rhs + pterm;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LHS_SET:  lhs <= amag << FRACTION_BITS;
      OP_D_SET:    d[cmd.idx] <= acc[DW-1:0];
      OP_T_LD:     t[cmd.idx] <= rd;
      OP_N_LD_ST:  n[cmd.idx] <= NW'(rd);
      OP_N_LD_ACC: n[cmd.idx] <= acc[NW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sep <= 1'b0;
    end else if (cmd.op == OP_CMP) begin
      sep <= (lhs > $unsigned(rhs));
    end
  end

  assign sts.mul_busy = mbusy;
  assign sts.mul_done = mbusy && mlast;
  assign sts.sep      = sep;

  a_mul_ends: assert property (@(posedge clk) disable iff (rst)
    sts.mul_done |=> !mbusy)
    else $error("multiplier stayed busy after its last slice");

endmodule

`default_nettype wire

// ----- design/obb_ctrl.sv -----
// Sequencer of the overlap unit: walks the centre difference, the fifteen
// test axes and their radius terms, and holds the result register.
// Depends on obb_pkg; drives obb_dpath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module obb_ctrl import obb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SLOT_W-1:0] slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit,
  output dp_cmd_t           cmd,
  input  dp_sts_t           sts
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_D_LD   = 5'd1;
  localparam logic [4:0] S_D_SUB  = 5'd2;
  localparam logic [4:0] S_D_SET  = 5'd3;
  localparam logic [4:0] S_AX     = 5'd4;
  localparam logic [4:0] S_NF     = 5'd5;
  localparam logic [4:0] S_TA     = 5'd6;
  localparam logic [4:0] S_C_CLR  = 5'd7;
  localparam logic [4:0] S_C_M1   = 5'd8;
  localparam logic [4:0] S_C_M2   = 5'd9;
  localparam logic [4:0] S_C_N    = 5'd10;
  localparam logic [4:0] S_L_CLR  = 5'd11;
  localparam logic [4:0] S_L_M    = 5'd12;
  localparam logic [4:0] S_L_SET  = 5'd13;
  localparam logic [4:0] S_R_INIT = 5'd14;
  localparam logic [4:0] S_T_SEL  = 5'd15;
  localparam logic [4:0] S_T_M    = 5'd16;
  localparam logic [4:0] S_T_H    = 5'd17;
  localparam logic [4:0] S_T_ADV  = 5'd18;
  localparam logic [4:0] S_CMP    = 5'd19;
  localparam logic [4:0] S_NEXT   = 5'd20;
  localparam logic [4:0] S_OUT    = 5'd21;
  localparam logic [4:0] S_MWAIT  = 5'd22;

  localparam logic [1:0] K_FA = 2'd0;
  localparam logic [1:0] K_FB = 2'd1;
  localparam logic [1:0] K_CR = 2'd2;

  logic [4:0] state, state_next;
  logic [4:0] ret, ret_next;
  logic [1:0] k, k_next;
  logic [1:0] kind, kind_next;
  logic [1:0] ai, ai_next;
  logic [1:0] bj, bj_next;
  logic       tbox, tbox_next;
  logic [1:0] tk, tk_next;
  logic       res, res_next;
  logic [1:0] k1, k2;
  logic       term_on;
  logic       out_load;
  logic [SLOT_W-1:0] tbase;
  logic [SLOT_W-1:0] fbase;

  always_comb begin
    k1      = (k == 2'd2) ? 2'd0 : k + 2'd1;
    k2      = (k == 2'd0) ? 2'd2 : k - 2'd1;
    tbase   = tbox ? SLOT_CB : SLOT_CA;
    fbase   = (kind == K_FB) ? SLOT_AXB : SLOT_AXA;
    // A face axis takes the other box's three terms; a cross axis A[i] x B[j]
    // skips the edges A[i] and B[j] that it was built from.
    case (kind)
      K_FA:    term_on = tbox;
      K_FB:    term_on = !tbox;
      default: term_on = tbox ? (tk != bj) : (tk != ai);
    endcase
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    k_next     = k;
    kind_next  = kind;
    ai_next    = ai;
    bj_next    = bj;
    tbox_next  = tbox;
    tk_next    = tk;
    res_next   = res;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (slot <= SLOT_HB) begin
            cmd.op = OP_WRITE;
          end
          if (slot == SLOT_HB) begin
            state_next = S_D_LD;
            k_next     = 2'd0;
          end
        end
      end
      S_D_LD: begin
        cmd.op      = OP_ACC_LD;
        cmd.rd_slot = SLOT_CA;
        cmd.rd_comp = k;
        state_next  = S_D_SUB;
      end
      S_D_SUB: begin
        cmd.op      = OP_ACC_SUB;
        cmd.rd_slot = SLOT_CB;
        cmd.rd_comp = k;
        state_next  = S_D_SET;
      end
      S_D_SET: begin
        cmd.op  = OP_D_SET;
        cmd.idx = k;
        k_next  = k1;
        if (k == 2'd2) begin
          state_next = S_AX;
          kind_next  = K_FA;
          ai_next    = 2'd0;
          bj_next    = 2'd0;
        end else begin
          state_next = S_D_LD;
        end
      end
      S_AX: begin
        k_next     = 2'd0;
        state_next = (kind == K_CR) ? S_TA : S_NF;
      end
      S_NF: begin
        cmd.op      = OP_N_LD_ST;
        cmd.idx     = k;
        cmd.rd_slot = fbase + SLOT_W'(ai);
        cmd.rd_comp = k;
        k_next      = k1;
        if (k == 2'd2) begin
          state_next = S_L_CLR;
        end
      end
      S_TA: begin
        cmd.op      = OP_T_LD;
        cmd.idx     = k;
        cmd.rd_slot = SLOT_AXA + SLOT_W'(ai);
        cmd.rd_comp = k;
        k_next      = k1;
        if (k == 2'd2) begin
          state_next = S_C_CLR;
        end
      end
      S_C_CLR: begin
        cmd.op     = OP_ACC_CLR;
        state_next = S_C_M1;
      end
      S_C_M1: begin
        cmd.op      = OP_MUL;
        cmd.xsel    = X_T;
        cmd.idx     = k1;
        cmd.ysel    = Y_ST;
        cmd.rd_slot = SLOT_AXB + SLOT_W'(bj);
        cmd.rd_comp = k2;
        ret_next    = S_C_M2;
        state_next  = S_MWAIT;
      end
      S_C_M2: begin
        cmd.op      = OP_MUL;
        cmd.xsel    = X_T;
        cmd.idx     = k2;
        cmd.ysel    = Y_ST;
        cmd.neg     = 1'b1;
        cmd.rd_slot = SLOT_AXB + SLOT_W'(bj);
        cmd.rd_comp = k1;
        ret_next    = S_C_N;
        state_next  = S_MWAIT;
      end
      S_C_N: begin
        cmd.op     = OP_N_LD_ACC;
        cmd.idx    = k;
        k_next     = k1;
        state_next = (k == 2'd2) ? S_L_CLR : S_C_CLR;
      end
      S_L_CLR: begin
        cmd.op     = OP_ACC_CLR;
        k_next     = 2'd0;
        state_next = S_L_M;
      end
      S_L_M: begin
        cmd.op     = OP_MUL;
        cmd.xsel   = X_N;
        cmd.ysel   = Y_D;
        cmd.idx    = k;
        k_next     = k1;
        ret_next   = (k == 2'd2) ? S_L_SET : S_L_M;
        state_next = S_MWAIT;
      end
      S_L_SET: begin
        cmd.op     = OP_LHS_SET;
        state_next = S_R_INIT;
      end
      S_R_INIT: begin
        cmd.rd_comp = ai;
        case (kind)
          K_FA: begin
            cmd.op      = OP_RHS_OWN;
            cmd.rd_slot = SLOT_HA;
          end
          K_FB: begin
            cmd.op      = OP_RHS_OWN;
            cmd.rd_slot = SLOT_HB;
          end
          default: cmd.op = OP_RHS_CLR;
        endcase
        tbox_next  = 1'b0;
        tk_next    = 2'd0;
        state_next = S_T_SEL;
      end
      S_T_SEL: begin
        if (term_on) begin
          cmd.op     = OP_ACC_CLR;
          k_next     = 2'd0;
          state_next = S_T_M;
        end else begin
          state_next = S_T_ADV;
        end
      end
      S_T_M: begin
        cmd.op      = OP_MUL;
        cmd.xsel    = X_N;
        cmd.idx     = k;
        cmd.ysel    = Y_ST;
        cmd.rd_slot = tbase + SLOT_W'(1) + SLOT_W'(tk);
        cmd.rd_comp = k;
        k_next      = k1;
        ret_next    = (k == 2'd2) ? S_T_H : S_T_M;
        state_next  = S_MWAIT;
      end
      S_T_H: begin
        cmd.op      = OP_MUL;
        cmd.xsel    = X_ACC;
        cmd.ysel    = Y_ST;
        cmd.mag     = 1'b1;
        cmd.to_rhs  = 1'b1;
        cmd.rd_slot = tbase + SLOT_W'(4);
        cmd.rd_comp = tk;
        ret_next    = S_T_ADV;
        state_next  = S_MWAIT;
      end
      S_T_ADV: begin
        if (tk == 2'd2) begin
          if (tbox) begin
            state_next = S_CMP;
          end else begin
            tbox_next  = 1'b1;
            tk_next    = 2'd0;
            state_next = S_T_SEL;
          end
        end else begin
          tk_next    = tk + 2'd1;
          state_next = S_T_SEL;
        end
      end
      S_CMP: begin
        cmd.op     = OP_CMP;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = S_AX;
        if (sts.sep) begin
          res_next   = 1'b0;
          state_next = S_OUT;
        end else begin
          case (kind)
            K_FA: begin
              if (ai == 2'd2) begin
                kind_next = K_FB;
                ai_next   = 2'd0;
              end else begin
                ai_next = ai + 2'd1;
              end
            end
            K_FB: begin
              if (ai == 2'd2) begin
                kind_next = K_CR;
                ai_next   = 2'd0;
                bj_next   = 2'd0;
              end else begin
                ai_next = ai + 2'd1;
              end
            end
            default: begin
              if (bj == 2'd2) begin
                bj_next = 2'd0;
                if (ai == 2'd2) begin
                  res_next   = 1'b1;
                  state_next = S_OUT;
                end else begin
                  ai_next = ai + 2'd1;
                end
              end else begin
                bj_next = bj + 2'd1;
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      S_MWAIT: begin
        if (sts.mul_done) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      k         <= 2'd0;
      kind      <= K_FA;
      ai        <= 2'd0;
      bj        <= 2'd0;
      tbox      <= 1'b0;
      tk        <= 2'd0;
      res       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      k     <= k_next;
      kind  <= kind_next;
      ai    <= ai_next;
      bj    <= bj_next;
      tbox  <= tbox_next;
      tk    <= tk_next;
      res   <= res_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit <= res;
    end
  end

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWAIT) |-> sts.mul_busy)
    else $error("waiting on an idle multiplier");

  a_no_overlap_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_MUL) |-> !sts.mul_busy)
    else $error("multiply started while the previous one runs");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the result state");

endmodule

`default_nettype wire

// ----- design/obb_overlap_test_unit.sv -----
// Top level of the oriented-box separating-axis overlap unit.
// Depends on obb_pkg, obb_ctrl and obb_dpath.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+-----------
//   in      | in_valid, in_stall, slot, comp_x/y/z | request in
//   out     | out_valid, out_stall, hit            | result out
//
// A load of slots 0 to 8 only stores the vector. A load of slot 9 also runs
// the test over the centre difference, the face axes and the cross axes,
// and the test ends early when an axis separates. The products are formed
// by the shared 32x33 multiplier, which takes the wide operand in four
// slices. Requests are stalled while a test runs. Reset is synchronous and
// makes all stored vectors read as zero; a result waits in its output
// register until taken, while further loads are accepted.
`timescale 1ns / 1ps
`default_nettype none

module obb_overlap_test_unit import obb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SLOT_W-1:0] slot,
  input  logic [IN_W-1:0]   comp_x,
  input  logic [IN_W-1:0]   comp_y,
  input  logic [IN_W-1:0]   comp_z,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hit
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  obb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .slot      (slot),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .cmd       (cmd),
    .sts       (sts)
  );

  obb_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .slot   (slot),
    .comp_x (comp_x),
    .comp_y (comp_y),
    .comp_z (comp_z)
  );

endmodule

`default_nettype wire
